/* hw/rtl/bgtr_pkg.sv */
package bgtr_pkg;

    // field and register widths
    localparam int ADDR_W     = 32;
    localparam int COLOR_W    = 32;
    localparam int DIM_W      = 13;
    localparam int KIND_W     = 2;
    localparam int CODE_W     = 8;
    localparam int GROW_W     = 4;
    localparam int BITS_W     = 8;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // font geometry
    localparam int GLYPH_ROWS   = 16;
    localparam int GLYPH_WIDTH  = 8;
    localparam int NUM_GLYPHS   = 256;
    localparam int MAX_DIM      = 4096;
    localparam int ROWS_EMITTED = 16;
    localparam int LINE_HEIGHT  = 16;

    localparam int STORE_DEPTH = NUM_GLYPHS * GLYPH_ROWS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ROW_CW      = $clog2(ROWS_EMITTED);

    localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

    // queues
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PW    = $clog2(CMD_DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PW    = $clog2(OUT_DEPTH);

    // reset values of the registers
    localparam logic [COLOR_W-1:0] RST_DRAW_COLOR   = COLOR_W'(32'h00FF_FFFF);
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_LINE_PITCH   = DIM_W'(640);
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = DIM_W'(480);
    localparam logic [ADDR_W-1:0]  RST_FRAME_BASE   = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_FONT  = 2'd0,
        KIND_START = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRAW_COLOR   = 3'd0,
        CFG_FRAME_WIDTH  = 3'd1,
        CFG_LINE_PITCH   = 3'd2,
        CFG_FRAME_HEIGHT = 3'd3,
        CFG_FRAME_BASE   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SETUP,
        BK_ROWS
    } t_bk_state;

    typedef struct packed {
        logic [COLOR_W-1:0] draw_color;
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   line_pitch;
        logic [DIM_W-1:0]   frame_height;
        logic [ADDR_W-1:0]  frame_base;
    } t_cfg;

    typedef struct packed {
        logic              is_char;
        logic [CODE_W-1:0] code;
        logic [GROW_W-1:0] grow;
        logic [BITS_W-1:0] bits;
        logic [DIM_W-1:0]  cur_x;
        logic [DIM_W-1:0]  cur_y;
    } t_cmd;

    typedef struct packed {
        logic               push;
        t_cmd               cmd;
    } t_cmd_wr;

    typedef struct packed {
        logic               empty;
        t_cmd               cmd;
    } t_cmd_rd;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [BITS_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               offscreen;
        logic               last;
    } t_res;

    function automatic logic glyph_hit(input logic [CODE_W-1:0] code,
                                       input logic [GROW_W-1:0] row);
        return (int'(code) < NUM_GLYPHS) && (int'(row) < GLYPH_ROWS);
    endfunction

    function automatic logic [STORE_AW-1:0] glyph_addr(input logic [CODE_W-1:0] code,
                                                       input logic [GROW_W-1:0] row);
        return STORE_AW'(int'(code) * GLYPH_ROWS + int'(row));
    endfunction

endpackage

/* hw/rtl/bitmap_glyph_text_renderer_top.sv */
// Text renderer for an 8x16 bitmap font into a linear 32-bit framebuffer.
// Items enter through a push/full queue port and are sorted at once: a start
// item or a newline only moves the cursor; font row writes and drawn
// characters are queued for the drawing engine, which owns the 4096-entry
// glyph store. A font row write goes into the store as it is dequeued. A
// drawn character is dequeued, then its start address is formed by a
// multiply, followed by 16 row results, one per cycle while the result queue
// has room, paced by the single read port of the glyph store. Results leave
// through an empty/pop queue port, oldest first. The glyph store is not
// cleared at reset; draw only glyphs that have been loaded. Configuration
// registers are written through the plain write port; the user must write
// them only while the block is idle, as the block does not enforce this.
module bitmap_glyph_text_renderer_top
    import bgtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [CODE_W-1:0]     i_char_code,
    input  logic [GROW_W-1:0]     i_glyph_row,
    input  logic [BITS_W-1:0]     i_row_bits,
    input  logic [COL_W-1:0]      i_cell_col,
    input  logic [ROW_W-1:0]      i_cell_row,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [BITS_W-1:0]     o_row_mask,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_offscreen,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd_wr cmd_wr;
    t_cmd_rd cmd_rd;
    logic    cmd_full;
    logic    cmd_pop;
    t_res    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.draw_color   <= RST_DRAW_COLOR;
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.line_pitch   <= RST_LINE_PITCH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.frame_base   <= RST_FRAME_BASE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DRAW_COLOR:   r_cfg.draw_color   <= i_cfg_data[COLOR_W-1:0];
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_LINE_PITCH:   r_cfg.line_pitch   <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_BASE:   r_cfg.frame_base   <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_full = cmd_full;

    bgtr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_cmd_full    (cmd_full),
        .i_kind        (i_kind),
        .i_char_code   (i_char_code),
        .i_glyph_row   (i_glyph_row),
        .i_row_bits    (i_row_bits),
        .i_cell_col    (i_cell_col),
        .i_cell_row    (i_cell_row),
        .i_frame_width (r_cfg.frame_width),
        .o_cmd_wr      (cmd_wr)
    );

    bgtr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_rd    (cmd_rd)
    );

    bgtr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd_rd  (cmd_rd),
        .o_cmd_pop (cmd_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (res)
    );

    assign o_pixel_address = res.addr;
    assign o_row_mask      = res.mask;
    assign o_pixel_color   = res.color;
    assign o_offscreen     = res.offscreen;
    assign o_last          = res.last;

endmodule

/* hw/rtl/bgtr_front.sv */
module bgtr_front
    import bgtr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_cmd_full,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [CODE_W-1:0] i_char_code,
    input  logic [GROW_W-1:0] i_glyph_row,
    input  logic [BITS_W-1:0] i_row_bits,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [DIM_W-1:0]  i_frame_width,
    output t_cmd_wr           o_cmd_wr
);

    logic [DIM_W-1:0] r_cur_x, n_cur_x;
    logic [DIM_W-1:0] r_cur_y, n_cur_y;
    logic             accept;
    logic [DIM_W-1:0] step_x;
    logic [DIM_W:0]   step_y;

    assign accept = i_push & ~i_cmd_full;

    always_comb begin
        n_cur_x          = r_cur_x;
        n_cur_y          = r_cur_y;
        o_cmd_wr.push    = 1'b0;
        o_cmd_wr.cmd.is_char = 1'b0;
        o_cmd_wr.cmd.code    = i_char_code;
        o_cmd_wr.cmd.grow    = i_glyph_row;
        o_cmd_wr.cmd.bits    = i_row_bits;
        o_cmd_wr.cmd.cur_x   = r_cur_x;
        o_cmd_wr.cmd.cur_y   = r_cur_y;
        step_x = r_cur_x + DIM_W'(GLYPH_WIDTH);
        step_y = {1'b0, r_cur_y} + (DIM_W+1)'(LINE_HEIGHT);
        if (accept) begin
            case (t_kind'(i_kind))
                KIND_FONT: begin
                    // out of range font writes are dropped here
                    o_cmd_wr.push = glyph_hit(i_char_code, i_glyph_row);
                end
                KIND_START: begin
                    n_cur_x = DIM_W'(int'(i_cell_col) * GLYPH_WIDTH);
                    n_cur_y = DIM_W'(int'(i_cell_row) * LINE_HEIGHT);
                end
                KIND_CHAR: begin
                    o_cmd_wr.cmd.is_char = 1'b1;
                    o_cmd_wr.push        = (i_char_code != NEWLINE_CODE);
                    // wrap when the next cell would not fit
                    if (({1'b0, step_x} + (DIM_W+1)'(GLYPH_WIDTH)) >
                        {1'b0, i_frame_width}) begin
                        n_cur_x = '0;
                        if (step_y > (DIM_W+1)'(MAX_DIM)) begin
                            n_cur_y = DIM_W'(MAX_DIM);
                        end else begin
                            n_cur_y = step_y[DIM_W-1:0];
                        end
                    end else begin
                        n_cur_x = step_x;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
        end
    end

endmodule

/* hw/rtl/bgtr_cmd_fifo.sv */
module bgtr_cmd_fifo
    import bgtr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd_wr i_wr,
    input  logic    i_pop,
    output logic    o_full,
    output t_cmd_rd o_rd
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_PW-1:0] r_head;
    logic [CMD_PW-1:0] r_tail;
    logic [CMD_PW:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full     = (r_cnt == (CMD_PW+1)'(CMD_DEPTH));
    assign o_rd.empty = (r_cnt == '0);
    assign o_rd.cmd   = r_mem[r_head];
    assign do_push    = i_wr.push & ~o_full;
    assign do_pop     = i_pop & ~o_rd.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= r_head + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/bgtr_back.sv */
module bgtr_back
    import bgtr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_cmd_rd i_cmd_rd,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_res    o_res
);

    // glyph store, one write and one registered read port
    logic [BITS_W-1:0]   r_store [STORE_DEPTH];
    logic [BITS_W-1:0]   r_rd_data;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;

    t_bk_state         r_state, n_state;
    logic [CODE_W-1:0] r_code;
    logic [DIM_W-1:0]  r_cx;
    logic [DIM_W-1:0]  r_cy;
    logic [ADDR_W-1:0] r_addr;
    logic [DIM_W:0]    r_y;
    logic [ROW_CW-1:0] r_row;

    // row stage waiting on the store read
    logic              r_s_v;
    logic [ADDR_W-1:0] r_s_addr;
    logic              r_s_off;
    logic              r_s_last;
    logic              r_s_hit;

    // result queue
    t_res              r_q [OUT_DEPTH];
    logic [OUT_PW-1:0] r_qh;
    logic [OUT_PW-1:0] r_qt;
    logic [OUT_PW:0]   r_qc;

    logic               q_pop;
    logic [OUT_PW+1:0]  occ;
    logic               issue_ok;
    logic [2*DIM_W-1:0] prod;
    logic [2*DIM_W:0]   pix;
    logic [GROW_W-1:0]  row_idx;
    t_res               push_res;

    assign occ      = {1'b0, r_qc} + (OUT_PW+2)'(r_s_v);
    assign issue_ok = (occ < (OUT_PW+2)'(OUT_DEPTH));
    assign prod     = r_cy * i_cfg.line_pitch;
    assign pix      = {1'b0, prod} + (2*DIM_W+1)'(r_cx);
    assign row_idx  = GROW_W'(r_row);

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = glyph_addr(i_cmd_rd.cmd.code, i_cmd_rd.cmd.grow);
        rd_en     = 1'b0;
        rd_addr   = glyph_addr(r_code, row_idx);
        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_rd.empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd_rd.cmd.is_char) begin
                        n_state = BK_SETUP;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
            end
            BK_SETUP: begin
                n_state = BK_ROWS;
            end
            BK_ROWS: begin
                if (issue_ok) begin
                    rd_en = 1'b1;
                    if (r_row == ROW_CW'(ROWS_EMITTED - 1)) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_cmd_rd.cmd.bits;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // character walk: address steps by one scanline per row
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd_rd.cmd.is_char) begin
            r_code <= i_cmd_rd.cmd.code;
            r_cx   <= i_cmd_rd.cmd.cur_x;
            r_cy   <= i_cmd_rd.cmd.cur_y;
        end
        if (r_state == BK_SETUP) begin
            r_addr <= i_cfg.frame_base + ADDR_W'({pix, 2'b00});
            r_y    <= {1'b0, r_cy};
            r_row  <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + ADDR_W'({i_cfg.line_pitch, 2'b00});
            r_y    <= r_y + 1'b1;
            r_row  <= r_row + 1'b1;
        end
        if (rd_en) begin
            r_s_addr <= r_addr;
            r_s_off  <= (r_y >= {1'b0, i_cfg.frame_height});
            r_s_last <= (r_row == ROW_CW'(ROWS_EMITTED - 1));
            r_s_hit  <= glyph_hit(r_code, row_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else begin
            r_s_v <= rd_en;
        end
    end

    always_comb begin
        push_res.addr      = r_s_addr;
        push_res.mask      = r_s_hit ? r_rd_data : '0;
        push_res.color     = i_cfg.draw_color;
        push_res.offscreen = r_s_off;
        push_res.last      = r_s_last;
    end

    assign o_empty = (r_qc == '0);
    assign o_res   = r_q[r_qh];
    assign q_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s_v) begin
            r_q[r_qt] <= push_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qh <= '0;
            r_qt <= '0;
            r_qc <= '0;
        end else begin
            if (r_s_v) begin
                r_qt <= r_qt + 1'b1;
            end
            if (q_pop) begin
                r_qh <= r_qh + 1'b1;
            end
            case ({r_s_v, q_pop})
                2'b10:   r_qc <= r_qc + 1'b1;
                2'b01:   r_qc <= r_qc - 1'b1;
                default: r_qc <= r_qc;
            endcase
        end
    end

endmodule
